// ===== hdl/engine_state_starter_lock_fsm_macros.svh =====
// Assertion macros shared by the engine state / starter lock RTL.
// Plain text only; no dependencies. Included by the modules that check themselves.
`ifndef ENGINE_STATE_STARTER_LOCK_FSM_MACROS_SVH
`define ENGINE_STATE_STARTER_LOCK_FSM_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ESSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ESSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must never be seen.
`define ESSL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/essl_pkg.sv =====
// Types and constants for the engine state / starter lock block.
// No dependencies; used by essl_fsm and engine_state_starter_lock_fsm.
package essl_pkg;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_OFF     = 2'd1,
        ST_RUNNING = 2'd2,
        ST_MOVING  = 2'd3
    } t_eng_state;

    // Config register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_RPM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVING_KPH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DEBOUNCE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_DISABLE = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned RPM_W      = 14;
    localparam int unsigned KPH_W      = 8;

    // Per-tick qualifiers computed in the input stage
    typedef struct packed {
        logic rpm_fresh;
        logic eng_on;
        logic moving;
        logic stopped;
    } t_tick;

    // One result beat
    typedef struct packed {
        t_eng_state state;
        logic       locked;
        logic       dis_pulse;
        logic       en_pulse;
    } t_result;

endpackage

// ===== hdl/essl_fsm.sv =====
// Engine state machine, stop debounce timer and starter lock latch.
// Depends on essl_pkg and engine_state_starter_lock_fsm_macros.svh.
`include "engine_state_starter_lock_fsm_macros.svh"

module essl_fsm (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  essl_pkg::t_tick                 i_tick,
    input  logic [essl_pkg::MS_W-1:0]       i_now_ms,
    input  logic [essl_pkg::CFG_DATA_W-1:0] i_off_debounce_ms,
    input  logic                            i_unlock_disable,
    output essl_pkg::t_result               o_result
);

    essl_pkg::t_eng_state          r_state, n_state;
    logic                          r_lock, n_lock;
    logic [essl_pkg::MS_W-1:0]     r_stop_since, n_stop_since;
    logic                          n_dis, n_en;

    logic [essl_pkg::MS_W-1:0]     stop_base;
    logic [essl_pkg::MS_W-1:0]     stop_elapsed;
    logic                          debounce_hit;

    // A zero timestamp means not armed: arm at this tick.
    assign stop_base    = (r_stop_since != '0) ? r_stop_since : i_now_ms;
    assign stop_elapsed = i_now_ms - stop_base;
    assign debounce_hit = stop_elapsed >=
                          {{(essl_pkg::MS_W-essl_pkg::CFG_DATA_W){1'b0}}, i_off_debounce_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= essl_pkg::ST_UNKNOWN;
            r_lock       <= 1'b0;
            r_stop_since <= '0;
        end else if (i_step) begin
            r_state      <= n_state;
            r_lock       <= n_lock;
            r_stop_since <= n_stop_since;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_lock       = r_lock;
        n_stop_since = r_stop_since;
        n_dis        = 1'b0;
        n_en         = 1'b0;
        if (!i_tick.rpm_fresh) begin
            n_state      = essl_pkg::ST_UNKNOWN;
            n_stop_since = '0;
        end else begin
            unique case (r_state) inside
                essl_pkg::ST_UNKNOWN, essl_pkg::ST_OFF: begin
                    if (i_tick.eng_on) begin
                        n_state      = essl_pkg::ST_RUNNING;
                        n_stop_since = '0;
                        n_lock       = 1'b1;
                        n_dis        = !r_lock;
                    end else if (r_state == essl_pkg::ST_UNKNOWN) begin
                        n_state      = essl_pkg::ST_OFF;
                        n_stop_since = i_tick.stopped ? i_now_ms : '0;
                    end
                end
                essl_pkg::ST_RUNNING: begin
                    if (i_tick.moving) begin
                        n_state      = essl_pkg::ST_MOVING;
                        n_stop_since = '0;
                    end else if (i_tick.stopped) begin
                        if (debounce_hit) begin
                            n_state      = essl_pkg::ST_OFF;
                            n_stop_since = '0;
                        end else begin
                            n_stop_since = stop_base;
                        end
                    end else begin
                        n_stop_since = '0;
                    end
                end
                essl_pkg::ST_MOVING: begin
                    if (i_tick.stopped) begin
                        if (debounce_hit) begin
                            n_state      = essl_pkg::ST_OFF;
                            n_stop_since = '0;
                            n_lock       = i_unlock_disable;
                            n_en         = !i_unlock_disable;
                        end else begin
                            n_stop_since = stop_base;
                        end
                    end else begin
                        n_stop_since = '0;
                    end
                end
                default: begin
                    n_state = essl_pkg::ST_UNKNOWN;
                end
            endcase
        end
    end

    assign o_result.state     = n_state;
    assign o_result.locked    = n_lock;
    assign o_result.dis_pulse = n_dis;
    assign o_result.en_pulse  = n_en;

    `ESSL_ASSERT_NEXT(a_stale_goes_unknown, i_clk, i_rst_n, i_step && !i_tick.rpm_fresh, r_state == essl_pkg::ST_UNKNOWN && r_stop_since == '0, "stale RPM did not force unknown")
    `ESSL_ASSERT_NEVER(a_pulses_exclusive, i_clk, i_rst_n, n_dis && n_en, "lock and unlock pulse together")
    `ESSL_ASSERT_IMPLY(a_unlock_from_moving, i_clk, i_rst_n, i_step && n_en, r_state == essl_pkg::ST_MOVING && n_state == essl_pkg::ST_OFF, "unlock pulse outside moving-to-off")
    `ESSL_ASSERT_NEXT(a_lock_holds, i_clk, i_rst_n, i_step && r_lock && !n_en, r_lock, "lock released without unlock pulse")
    `ESSL_ASSERT_IMPLY(a_unknown_disarmed, i_clk, i_rst_n, r_state == essl_pkg::ST_UNKNOWN, r_stop_since == '0, "stop timer armed in unknown")

endmodule

// ===== hdl/engine_state_starter_lock_fsm.sv =====
// Top level of the engine state / starter lock block: config registers,
// input stage, result register. Depends on essl_pkg and essl_fsm.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------------
//  tick in   | input     | i_valid / o_stall  | i_now_ms, i_rpm_seen, i_rpm_update_ms,
//            |           |                    | i_speed_seen, i_speed_update_ms,
//            |           |                    | i_engine_rpm, i_speed_kph
//  result    | output    | o_valid / i_stall  | o_eng_state, o_starter_locked,
//            |           |                    | o_disable_pulse, o_enable_pulse
//  config    | input     | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// One tick beat per cycle unless stalled; input stage, then result register.
// The state update happens in the same cycle a tick leaves the input stage, so
// ticks are evaluated strictly in order with no bubbles between them.
// Reset (synchronous, active low) puts the FSM in unknown, unlocked, timer disarmed,
// and loads the config defaults.
// A stalled result holds; the input stage still takes one more tick behind it.
//
`include "engine_state_starter_lock_fsm_macros.svh"

module engine_state_starter_lock_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [essl_pkg::MS_W-1:0]           i_now_ms,
    input  logic                                i_rpm_seen,
    input  logic [essl_pkg::MS_W-1:0]           i_rpm_update_ms,
    input  logic                                i_speed_seen,
    input  logic [essl_pkg::MS_W-1:0]           i_speed_update_ms,
    input  logic [essl_pkg::RPM_W-1:0]          i_engine_rpm,
    input  logic [essl_pkg::KPH_W-1:0]          i_speed_kph,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_eng_state,
    output logic                                o_starter_locked,
    output logic                                o_disable_pulse,
    output logic                                o_enable_pulse,
    // config writes
    input  logic                                i_cfg_we,
    input  logic [essl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [essl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    // ---------------- config registers ----------------
    logic [essl_pkg::CFG_DATA_W-1:0] r_signal_timeout_ms;
    logic [essl_pkg::RPM_W-1:0]      r_running_rpm_min;
    logic [essl_pkg::KPH_W-1:0]      r_moving_kph_min;
    logic [essl_pkg::CFG_DATA_W-1:0] r_off_debounce_ms;
    logic                            r_unlock_disable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signal_timeout_ms <= 16'd1000;
            r_running_rpm_min   <= 14'd500;
            r_moving_kph_min    <= 8'd5;
            r_off_debounce_ms   <= 16'd3000;
            r_unlock_disable    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                essl_pkg::CFG_SIGNAL_TIMEOUT: r_signal_timeout_ms <= i_cfg_wdata;
                essl_pkg::CFG_RUNNING_RPM:    r_running_rpm_min   <= i_cfg_wdata[essl_pkg::RPM_W-1:0];
                essl_pkg::CFG_MOVING_KPH:     r_moving_kph_min    <= i_cfg_wdata[essl_pkg::KPH_W-1:0];
                essl_pkg::CFG_OFF_DEBOUNCE:   r_off_debounce_ms   <= i_cfg_wdata;
                essl_pkg::CFG_UNLOCK_DISABLE: r_unlock_disable    <= i_cfg_wdata[0];
                default: ; // unmapped index: ignored
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;     // input stage holds a tick
    logic r_out_valid;    // result register holds a beat
    logic advance;        // result register can take a new beat
    logic fire;           // input stage moves to the result register (FSM steps)
    logic in_accept;

    assign advance   = !r_out_valid || !i_stall;
    assign fire      = r_s1_valid && advance;
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // ---------------- input stage ----------------
    // Freshness and thresholds only depend on the tick and static config,
    // so they are resolved before the register; ages wrap modulo 2^32.
    logic [essl_pkg::MS_W-1:0] rpm_age;
    logic [essl_pkg::MS_W-1:0] spd_age;
    logic                      rpm_fresh, spd_fresh, eng_on;
    essl_pkg::t_tick           tick_in, r_tick;
    logic [essl_pkg::MS_W-1:0] r_now_ms;
    logic [essl_pkg::MS_W-1:0] timeout_ext;

    assign timeout_ext = {{(essl_pkg::MS_W-essl_pkg::CFG_DATA_W){1'b0}}, r_signal_timeout_ms};
    assign rpm_age     = i_now_ms - i_rpm_update_ms;
    assign spd_age     = i_now_ms - i_speed_update_ms;
    assign rpm_fresh   = i_rpm_seen && (rpm_age <= timeout_ext);
    assign spd_fresh   = i_speed_seen && (spd_age <= timeout_ext);
    assign eng_on      = i_engine_rpm >= r_running_rpm_min;

    assign tick_in.rpm_fresh = rpm_fresh;
    assign tick_in.eng_on    = eng_on;
    assign tick_in.moving    = eng_on && spd_fresh && (i_speed_kph >= r_moving_kph_min);
    assign tick_in.stopped   = (i_engine_rpm == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_tick   <= tick_in;
            r_now_ms <= i_now_ms;
        end
    end

    // ---------------- state machine ----------------
    essl_pkg::t_result fsm_result;

    essl_fsm u_fsm (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (fire),
        .i_tick            (r_tick),
        .i_now_ms          (r_now_ms),
        .i_off_debounce_ms (r_off_debounce_ms),
        .i_unlock_disable  (r_unlock_disable),
        .o_result          (fsm_result)
    );

    // ---------------- result register ----------------
    essl_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= fsm_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_eng_state      = r_result.state;
    assign o_starter_locked = r_result.locked;
    assign o_disable_pulse  = r_result.dis_pulse;
    assign o_enable_pulse   = r_result.en_pulse;

    `ESSL_ASSERT_NEXT(a_fire_gives_beat, i_clk, i_rst_n, fire, r_out_valid, "stepped tick left no result beat")
    `ESSL_ASSERT_NEXT(a_stalled_beat_kept, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid && $stable(r_result), "stalled result beat lost or changed")
    `ESSL_ASSERT_IMPLY(a_no_step_when_blocked, i_clk, i_rst_n, r_out_valid && i_stall, !fire, "FSM stepped while result was stalled")

endmodule

// ===== sim/tb_engine_state_starter_lock_fsm.sv =====
// Self-checking testbench for engine_state_starter_lock_fsm: a clocked driver and
// monitor around a local engine-state / starter-lock predictor.
// Depends on essl_pkg and the block's RTL only.
module tb_engine_state_starter_lock_fsm;
    import essl_pkg::*;

    // Register values loaded by reset
    localparam logic [15:0] RST_TIMEOUT  = 16'd1000;
    localparam logic [13:0] RST_RPM_MIN  = 14'd500;
    localparam logic [7:0]  RST_KPH_MIN  = 8'd5;
    localparam logic [15:0] RST_DEBOUNCE = 16'd3000;
    localparam logic        RST_UNLOCK   = 1'b0;

    localparam int MAX_WAIT      = 18;   // longest gap / stall drawn per beat
    localparam int SETTLE_CYCLES = 8;    // idle time after the last result has been checked
    localparam int IDLE_LIMIT    = 3000; // cycles without any beat before giving up
    localparam int N_PHASES      = 8;
    localparam int PHASE_TICKS   = 72;

    // One evaluation tick as driven on the input channel
    typedef struct packed {
        logic [MS_W-1:0]  now_ms;
        logic             rpm_seen;
        logic [MS_W-1:0]  rpm_upd;
        logic             speed_seen;
        logic [MS_W-1:0]  spd_upd;
        logic [RPM_W-1:0] rpm;
        logic [KPH_W-1:0] kph;
    } t_tick_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [MS_W-1:0]       i_now_ms = '0;
    logic                  i_rpm_seen = 1'b0;
    logic [MS_W-1:0]       i_rpm_update_ms = '0;
    logic                  i_speed_seen = 1'b0;
    logic [MS_W-1:0]       i_speed_update_ms = '0;
    logic [RPM_W-1:0]      i_engine_rpm = '0;
    logic [KPH_W-1:0]      i_speed_kph = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_eng_state;
    logic                  o_starter_locked;
    logic                  o_disable_pulse;
    logic                  o_enable_pulse;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    engine_state_starter_lock_fsm uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_now_ms          (i_now_ms),
        .i_rpm_seen        (i_rpm_seen),
        .i_rpm_update_ms   (i_rpm_update_ms),
        .i_speed_seen      (i_speed_seen),
        .i_speed_update_ms (i_speed_update_ms),
        .i_engine_rpm      (i_engine_rpm),
        .i_speed_kph       (i_speed_kph),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_eng_state       (o_eng_state),
        .o_starter_locked  (o_starter_locked),
        .o_disable_pulse   (o_disable_pulse),
        .o_enable_pulse    (o_enable_pulse),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: register copies and engine state mirror
    // ------------------------------------------------------------------
    logic [15:0]  cfg_timeout  = RST_TIMEOUT;
    logic [13:0]  cfg_rpm_min  = RST_RPM_MIN;
    logic [7:0]   cfg_kph_min  = RST_KPH_MIN;
    logic [15:0]  cfg_debounce = RST_DEBOUNCE;
    logic         cfg_unlock_dis = RST_UNLOCK;

    t_eng_state   eng_mirror  = ST_UNKNOWN;
    logic         lock_mirror = 1'b0;
    logic [31:0]  stop_mark   = '0;   // 0 means the stop debounce is not armed

    t_tick_item   tick_backlog[$];    // ticks waiting to be driven
    t_result      status_due[$];      // predicted result beats, oldest first
    int           errors = 0;
    int           n_sent = 0;         // ticks handed to the driver
    int           n_done = 0;         // result beats checked

    // Advance the mirror by one tick and return the result beat it should produce.
    function automatic t_result advance_engine(input t_tick_item tk);
        t_result     res;
        logic [31:0] rpm_age;
        logic [31:0] spd_age;
        logic        rpm_ok;
        logic        spd_ok;
        logic        eng_on;
        logic        moving;
        logic        stopped;
        logic        dis;
        logic        en;
        rpm_age = tk.now_ms - tk.rpm_upd;
        spd_age = tk.now_ms - tk.spd_upd;
        rpm_ok  = tk.rpm_seen && (rpm_age <= {16'd0, cfg_timeout});
        spd_ok  = tk.speed_seen && (spd_age <= {16'd0, cfg_timeout});
        dis = 1'b0;
        en  = 1'b0;
        if (!rpm_ok) begin
            // Stale RPM: unknown, debounce dropped, latch untouched
            eng_mirror = ST_UNKNOWN;
            stop_mark  = '0;
        end else begin
            eng_on  = tk.rpm >= cfg_rpm_min;
            moving  = eng_on && spd_ok && (tk.kph >= cfg_kph_min);
            stopped = tk.rpm == '0;
            case (eng_mirror) inside
                ST_UNKNOWN, ST_OFF: begin
                    if (eng_on) begin
                        eng_mirror = ST_RUNNING;
                        stop_mark  = '0;
                        if (!lock_mirror) begin
                            lock_mirror = 1'b1;
                            dis = 1'b1;
                        end
                    end else if (eng_mirror == ST_UNKNOWN) begin
                        eng_mirror = ST_OFF;
                        stop_mark  = stopped ? tk.now_ms : 32'd0;
                    end
                end
                ST_RUNNING: begin
                    if (moving) begin
                        eng_mirror = ST_MOVING;
                        stop_mark  = '0;
                    end else if (stopped) begin
                        if (stop_mark == '0)
                            stop_mark = tk.now_ms;
                        if (tk.now_ms - stop_mark >= {16'd0, cfg_debounce}) begin
                            stop_mark  = '0;
                            eng_mirror = ST_OFF;
                        end
                    end else begin
                        stop_mark = '0;
                    end
                end
                default: begin
                    // Moving: any nonzero RPM keeps it moving and disarms the debounce
                    if (stopped) begin
                        if (stop_mark == '0)
                            stop_mark = tk.now_ms;
                        if (tk.now_ms - stop_mark >= {16'd0, cfg_debounce}) begin
                            eng_mirror = ST_OFF;
                            if (cfg_unlock_dis) begin
                                lock_mirror = 1'b1;
                            end else begin
                                lock_mirror = 1'b0;
                                en = 1'b1;
                            end
                            stop_mark = '0;
                        end
                    end else begin
                        stop_mark = '0;
                    end
                end
            endcase
        end
        res.state     = eng_mirror;
        res.locked    = lock_mirror;
        res.dis_pulse = dis;
        res.en_pulse  = en;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random tick generation: driving profiles with random content, plus noise
    // ------------------------------------------------------------------
    logic [31:0] gen_now  = '0;
    int          seg_left = 0;
    int          seg_kind = 0;

    // Telemetry age: mostly fresh, sometimes right at or just past the timeout, or random
    function automatic logic [31:0] telemetry_age();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return {16'd0, cfg_timeout} + 32'd1;
            1:       return {16'd0, cfg_timeout};
            2:       return $urandom;
            default: return $urandom_range(0, cfg_timeout);
        endcase
    endfunction

    function automatic t_tick_item make_random_tick();
        t_tick_item tk;
        if ($urandom_range(0, 99) < 12) begin
            tk.now_ms     = $urandom;
            tk.rpm_seen   = 1'($urandom_range(0, 1));
            tk.rpm_upd    = $urandom;
            tk.speed_seen = 1'($urandom_range(0, 1));
            tk.spd_upd    = $urandom;
            tk.rpm        = RPM_W'($urandom_range(0, (1 << RPM_W) - 1));
            tk.kph        = KPH_W'($urandom_range(0, (1 << KPH_W) - 1));
            return tk;
        end
        if (seg_left == 0) begin
            seg_kind = $urandom_range(0, 4);
            seg_left = $urandom_range(2, 14);
        end
        seg_left--;
        // Step scales with the debounce so that stops can complete
        gen_now += $urandom_range(0, cfg_debounce / 3 + 20);
        tk.now_ms     = gen_now;
        tk.rpm_seen   = $urandom_range(0, 29) != 0;
        tk.rpm_upd    = gen_now - telemetry_age();
        tk.speed_seen = $urandom_range(0, 19) != 0;
        tk.spd_upd    = gen_now - telemetry_age();
        case (seg_kind)
            0: begin    // engine stopped, standing
                tk.rpm = '0;
                tk.kph = '0;
            end
            1: begin    // turning, below the running threshold
                tk.rpm = (cfg_rpm_min > 1) ? RPM_W'($urandom_range(1, cfg_rpm_min - 1)) : '0;
                tk.kph = KPH_W'($urandom_range(0, 255));
            end
            2: begin    // running, standing or slow
                tk.rpm = RPM_W'($urandom_range(cfg_rpm_min, (1 << RPM_W) - 1));
                tk.kph = (cfg_kph_min > 0) ? KPH_W'($urandom_range(0, cfg_kph_min - 1)) : '0;
            end
            3: begin    // driving
                tk.rpm = RPM_W'($urandom_range(cfg_rpm_min, (1 << RPM_W) - 1));
                tk.kph = KPH_W'($urandom_range(cfg_kph_min, 255));
            end
            default: begin  // stalled engine while rolling
                tk.rpm = '0;
                tk.kph = KPH_W'($urandom_range(0, 255));
            end
        endcase
        return tk;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one tick beat at a time from the backlog, random gaps
    // ------------------------------------------------------------------
    t_tick_item cur_tick;
    int         src_wait = 0;
    bit         src_calm = 1'b0;

    always @(posedge i_clk) begin
        logic nxt_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nxt_valid = i_valid;
            if (i_valid && !o_stall) begin
                status_due.push_back(advance_engine(cur_tick));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_wait > 0) begin
                    src_wait--;
                end else if (tick_backlog.size() > 0) begin
                    cur_tick = tick_backlog.pop_front();
                    i_now_ms          <= cur_tick.now_ms;
                    i_rpm_seen        <= cur_tick.rpm_seen;
                    i_rpm_update_ms   <= cur_tick.rpm_upd;
                    i_speed_seen      <= cur_tick.speed_seen;
                    i_speed_update_ms <= cur_tick.spd_upd;
                    i_engine_rpm      <= cur_tick.rpm;
                    i_speed_kph       <= cur_tick.kph;
                    nxt_valid = 1'b1;
                    // Gap before the following beat; calm stretches run back to back
                    if ($urandom_range(0, 39) == 0)
                        src_calm = !src_calm;
                    src_wait = src_calm ? 0 : $urandom_range(0, MAX_WAIT);
                end
            end
            i_valid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stalls, every result beat checked against the oldest prediction
    // ------------------------------------------------------------------
    int sink_wait = 0;
    bit sink_calm = 1'b0;

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (status_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual state %0d",
                             $time, o_eng_state);
                    errors++;
                end else begin
                    due = status_due.pop_front();
                    check_field("eng_state", due.state, o_eng_state);
                    check_field("starter_locked", due.locked, o_starter_locked);
                    check_field("disable_pulse", due.dis_pulse, o_disable_pulse);
                    check_field("enable_pulse", due.en_pulse, o_enable_pulse);
                    n_done++;
                end
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_wait = sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            i_stall <= (sink_wait != 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles in a row with no beat on either channel
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results still due",
                     $time, idle_cycles, status_due.size());
            $display("tb_engine_state_starter_lock_fsm: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_SIGNAL_TIMEOUT: cfg_timeout    = val;
            CFG_RUNNING_RPM:    cfg_rpm_min    = val[RPM_W-1:0];
            CFG_MOVING_KPH:     cfg_kph_min    = val[KPH_W-1:0];
            CFG_OFF_DEBOUNCE:   cfg_debounce   = val;
            CFG_UNLOCK_DISABLE: cfg_unlock_dis = val[0];
            default: ;  // unused indexes are dropped by the block
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [15:0] tmo, input logic [13:0] rpm_min,
                                  input logic [7:0] kph_min, input logic [15:0] deb,
                                  input logic unl);
        write_reg(CFG_SIGNAL_TIMEOUT, tmo);
        write_reg(CFG_RUNNING_RPM, CFG_DATA_W'(rpm_min));
        write_reg(CFG_MOVING_KPH, CFG_DATA_W'(kph_min));
        write_reg(CFG_OFF_DEBOUNCE, deb);
        write_reg(CFG_UNLOCK_DISABLE, CFG_DATA_W'(unl));
    endtask

    task automatic queue_tick(input logic [31:0] now, input logic rs, input logic [31:0] ru,
                              input logic ss, input logic [31:0] su,
                              input logic [13:0] rpm, input logic [7:0] kph);
        t_tick_item tk;
        tk.now_ms     = now;
        tk.rpm_seen   = rs;
        tk.rpm_upd    = ru;
        tk.speed_seen = ss;
        tk.spd_upd    = su;
        tk.rpm        = rpm;
        tk.kph        = kph;
        tick_backlog.push_back(tk);
        n_sent++;
    endtask

    // Block until every queued tick has come back as a checked result, then settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (n_done != n_sent)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int ix;
        int p;
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed walk with reset settings (timeout 1000, 500 rpm, 5 kph, 3000 ms)
        queue_tick(32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 14'd0, 8'd0);           // never seen
        queue_tick('1, 1'b1, '1, 1'b1, '1, '1, '1);                         // all ones: lock
        queue_tick(32'd0, 1'b1, '1, 1'b1, '1, '1, '1);                      // age across wrap
        queue_tick(32'd100, 1'b1, 32'd100, 1'b1, 32'd100, 14'd0, 8'd0);     // arm stop
        queue_tick(32'd3100, 1'b1, 32'd3100, 1'b1, 32'd3100, 14'd0, 8'd0);  // off + unlock
        queue_tick(32'd3200, 1'b1, 32'd3200, 1'b1, 32'd3200, 14'd600, 8'd0);
        queue_tick(32'd5000, 1'b1, 32'd3999, 1'b1, 32'd5000, 14'd600, 8'd0); // one ms stale
        queue_tick(32'd6000, 1'b1, 32'd5000, 1'b1, 32'd6000, 14'd0, 8'd0);  // age at limit
        queue_tick(32'd6500, 1'b1, 32'd6500, 1'b1, 32'd5400, 14'd700, 8'd200); // speed stale
        queue_tick(32'd6600, 1'b1, 32'd6600, 1'b0, 32'd6600, 14'd700, 8'd200); // speed unseen
        queue_tick(32'd0, 1'b1, 32'd0, 1'b1, 32'd0, 14'd0, 8'd0);           // stamp zero: stays unarmed
        queue_tick(32'd2999, 1'b1, 32'd2999, 1'b1, 32'd2999, 14'd0, 8'd0);  // re-arms here
        queue_tick(32'd5999, 1'b1, 32'd5999, 1'b1, 32'd5999, 14'd0, 8'd0);  // running -> off
        queue_tick(32'd6000, 1'b1, 32'd6000, 1'b1, 32'd6000, 14'd500, 8'd0); // rpm at min
        queue_tick(32'd6001, 1'b1, 32'd6001, 1'b1, 32'd6001, 14'd500, 8'd5); // kph at min
        queue_tick(32'd6002, 1'b1, 32'd6002, 1'b1, 32'd6002, 14'd100, 8'd0); // slow, no stop
        queue_tick(32'd7000, 1'b1, 32'd7000, 1'b1, 32'd7000, 14'd0, 8'd0);
        queue_tick(32'd9999, 1'b1, 32'd9999, 1'b1, 32'd9999, 14'd0, 8'd0);  // one ms short
        queue_tick(32'd10000, 1'b1, 32'd10000, 1'b1, 32'd10000, 14'd0, 8'd0);
        wait_drained();

        // Unlock disabled: the debounced stop keeps the starter locked
        write_reg(CFG_UNLOCK_DISABLE, CFG_DATA_W'(1'b1));
        queue_tick(32'd20000, 1'b0, 32'd20000, 1'b1, 32'd20000, 14'd800, 8'd0);
        queue_tick(32'd20100, 1'b1, 32'd20100, 1'b1, 32'd20100, 14'd800, 8'd0);
        queue_tick(32'd20200, 1'b1, 32'd20200, 1'b1, 32'd20200, 14'd800, 8'd60);
        queue_tick(32'd21000, 1'b1, 32'd21000, 1'b1, 32'd21000, 14'd0, 8'd0);
        queue_tick(32'd24000, 1'b1, 32'd24000, 1'b1, 32'd24000, 14'd0, 8'd0);
        wait_drained();

        // Writes to unused indexes must leave every register alone
        for (ix = CFG_UNLOCK_DISABLE + 1; ix < (1 << CFG_IDX_W); ix++)
            write_reg(CFG_IDX_W'(ix), CFG_DATA_W'($urandom));

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0: write_all_regs(RST_TIMEOUT, RST_RPM_MIN, RST_KPH_MIN, RST_DEBOUNCE, 1'b0);
                1: write_all_regs(16'd0, 14'd0, 8'd0, 16'd0, 1'b0);
                2: write_all_regs('1, '1, '1, '1, 1'b1);
                3: write_all_regs('1, 14'd0, '1, 16'd0, 1'b0);
                default: write_all_regs(16'($urandom_range(0, 65535)),
                                        RPM_W'($urandom_range(0, (1 << RPM_W) - 1)),
                                        KPH_W'($urandom_range(0, 255)),
                                        16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 4000)),
                                        1'($urandom_range(0, 1)));
            endcase
            // Start some phases just below the ms counter wrap
            gen_now  = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                                   : $urandom;
            seg_left = 0;
            for (k = 0; k < PHASE_TICKS; k++) begin
                // Mid-phase, hold the sender until everything in flight has returned
                if (k == PHASE_TICKS / 2)
                    wait_drained();
                tick_backlog.push_back(make_random_tick());
                n_sent++;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("tb_engine_state_starter_lock_fsm: PASS");
        else
            $display("tb_engine_state_starter_lock_fsm: FAIL");
        $finish;
    end

endmodule
